// ===== hdl/retm_pkg.sv =====
`default_nettype none

package retm_pkg;

  localparam int STAMP_W = 27;
  localparam int FID_W   = 16;

  // commands
  localparam logic [2:0] CMD_LINK_UP   = 3'd0;
  localparam logic [2:0] CMD_LINK_LOST = 3'd1;
  localparam logic [2:0] CMD_RETRY     = 3'd2;
  localparam logic [2:0] CMD_MSG       = 3'd3;
  localparam logic [2:0] CMD_ENTER     = 3'd4;
  localparam logic [2:0] CMD_RELEASE   = 3'd5;

  // message kinds
  localparam logic [2:0] KIND_PROBE    = 3'd0;
  localparam logic [2:0] KIND_ELECTION = 3'd1;
  localparam logic [2:0] KIND_ELECTED  = 3'd2;
  localparam logic [2:0] KIND_CLEAR    = 3'd3;
  localparam logic [2:0] KIND_MARKER   = 3'd4;

  // ring phase
  localparam logic [1:0] RING_INIT = 2'd0;
  localparam logic [1:0] RING_DOWN = 2'd1;
  localparam logic [1:0] RING_UP   = 2'd2;

  // mutex phase
  localparam logic [1:0] MX_INIT     = 2'd0;
  localparam logic [1:0] MX_RELEASED = 2'd1;
  localparam logic [1:0] MX_WANTED   = 2'd2;
  localparam logic [1:0] MX_HELD     = 2'd3;

  typedef struct packed {
    logic [1:0]         ring_phase;
    logic               participant;
    logic               leader_known;
    logic               regen_active;
    logic [STAMP_W-1:0] marker_time;
    logic [1:0]         mutex_phase;
    logic               clear_deferred;
    logic               retry_armed;
  } retm_state_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [2:0]         msg_kind;
    logic [FID_W-1:0]   msg_id;
    logic [STAMP_W-1:0] msg_stamp;
    logic [STAMP_W-1:0] now_time;
  } retm_item_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         kind;
    logic [FID_W-1:0]   id;
    logic [STAMP_W-1:0] stamp;
  } retm_msg_t;

endpackage

`default_nettype wire

// ===== hdl/retm_in_if.sv =====
`default_nettype none

interface retm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [2:0]  msg_kind;
  logic [15:0] msg_id;
  logic [26:0] msg_stamp;
  logic [26:0] now_time;

  modport source (output valid, cmd, msg_kind, msg_id, msg_stamp, now_time, input ready);
  modport sink   (input valid, cmd, msg_kind, msg_id, msg_stamp, now_time, output ready);
endinterface

`default_nettype wire

// ===== hdl/retm_out_if.sv =====
`default_nettype none

interface retm_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [2:0]  send_kind;
  logic [15:0] send_id;
  logic [26:0] send_stamp;
  logic        last;
  logic [1:0]  ring_state;
  logic        is_participant;
  logic        leader_valid;
  logic [15:0] leader_id;
  logic [1:0]  access_state;
  logic        marker_pass_active;

  modport source (
    output valid, send_valid, send_kind, send_id, send_stamp, last, ring_state,
           is_participant, leader_valid, leader_id, access_state, marker_pass_active,
    input  ready
  );
  modport sink (
    input  valid, send_valid, send_kind, send_id, send_stamp, last, ring_state,
           is_participant, leader_valid, leader_id, access_state, marker_pass_active,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/retm_step.sv =====
`default_nettype none

module retm_step #(
  parameter int IdW = 16
) (
  input  retm_pkg::retm_state_t st,
  input  logic [IdW-1:0]        leader_ident,
  input  logic [IdW-1:0]        own_id,
  input  retm_pkg::retm_item_t  item,
  output retm_pkg::retm_state_t st_nxt,
  output logic [IdW-1:0]        leader_ident_nxt,
  output retm_pkg::retm_msg_t   m0,
  output retm_pkg::retm_msg_t   m1,
  output logic                  two
);
  import retm_pkg::*;

  logic [IdW-1:0]   id;
  logic             leader;
  logic [FID_W-1:0] own_w;
  logic [FID_W-1:0] id_w;

  assign id     = item.msg_id[IdW-1:0];
  assign leader = st.leader_known && (leader_ident == own_id);
  assign own_w  = FID_W'(own_id);
  assign id_w   = FID_W'(id);

  always_comb begin
    st_nxt           = st;
    leader_ident_nxt = leader_ident;
    m0               = '0;
    m1               = '0;
    two              = 1'b0;
    case (item.cmd)
      CMD_LINK_UP: begin
        st_nxt.ring_phase  = RING_DOWN;
        st_nxt.retry_armed = 1'b1;
        m0 = '{1'b1, KIND_PROBE, own_w, '0};
      end
      CMD_LINK_LOST: begin
        st_nxt.ring_phase = RING_DOWN;
      end
      CMD_RETRY: begin
        if (st.retry_armed) begin
          m0 = '{1'b1, KIND_PROBE, own_w, '0};
        end
      end
      CMD_MSG: begin
        case (item.msg_kind)
          KIND_PROBE: begin
            if (id == own_id) begin
              st_nxt.retry_armed  = 1'b0;
              st_nxt.ring_phase   = RING_UP;
              st_nxt.leader_known = 1'b0;
              st_nxt.participant  = 1'b1;
              leader_ident_nxt    = '0;
              m0 = '{1'b1, KIND_ELECTION, own_w, '0};
            end else begin
              m0 = '{1'b1, KIND_PROBE, id_w, '0};
            end
          end
          KIND_ELECTION: begin
            if (id > own_id) begin
              st_nxt.leader_known = 1'b0;
              st_nxt.participant  = 1'b1;
              leader_ident_nxt    = '0;
              m0 = '{1'b1, KIND_ELECTION, id_w, '0};
            end else if (id < own_id) begin
              if (!st.participant) begin
                st_nxt.leader_known = 1'b0;
                st_nxt.participant  = 1'b1;
                leader_ident_nxt    = '0;
                m0 = '{1'b1, KIND_ELECTION, own_w, '0};
              end
            end else begin
              // our own election came back round: we win
              st_nxt.leader_known = 1'b1;
              st_nxt.participant  = 1'b0;
              leader_ident_nxt    = own_id;
              m0 = '{1'b1, KIND_ELECTED, own_w, '0};
            end
          end
          KIND_ELECTED: begin
            if (st.mutex_phase == MX_INIT) begin
              st_nxt.mutex_phase = MX_RELEASED;
            end
            if (id != own_id) begin
              st_nxt.leader_known = 1'b1;
              st_nxt.participant  = 1'b0;
              leader_ident_nxt    = id;
              m0 = '{1'b1, KIND_ELECTED, id_w, '0};
            end else if (leader) begin
              // announcement finished its lap: leader starts the clear pass
              st_nxt.regen_active = 1'b1;
              st_nxt.marker_time  = '0;
              m0 = '{1'b1, KIND_CLEAR, '0, '0};
            end
          end
          KIND_CLEAR: begin
            if (st.mutex_phase != MX_HELD) begin
              if (leader) begin
                st_nxt.marker_time = item.now_time;
                m0 = '{1'b1, KIND_MARKER, '0, item.now_time};
              end else begin
                st_nxt.regen_active = 1'b1;
                st_nxt.marker_time  = '0;
                m0 = '{1'b1, KIND_CLEAR, '0, '0};
              end
            end else begin
              st_nxt.clear_deferred = 1'b1;
            end
          end
          KIND_MARKER: begin
            if (st.regen_active) begin
              if (leader) begin
                if (item.msg_stamp == st.marker_time) begin
                  st_nxt.regen_active = 1'b0;
                  m0 = '{1'b1, KIND_MARKER, '0, item.msg_stamp};
                end
              end else if (st.marker_time == '0) begin
                st_nxt.regen_active = 1'b0;
                st_nxt.marker_time  = item.msg_stamp;
                m0 = '{1'b1, KIND_MARKER, '0, item.msg_stamp};
              end else if (st.marker_time == item.msg_stamp) begin
                m0 = '{1'b1, KIND_MARKER, '0, item.msg_stamp};
              end
            end else begin
              if (st.mutex_phase == MX_WANTED && st.marker_time != '0) begin
                st_nxt.mutex_phase = MX_HELD;
              end else if (st.mutex_phase == MX_RELEASED) begin
                m0 = '{1'b1, KIND_MARKER, '0, item.msg_stamp};
              end
            end
          end
          default: begin
          end
        endcase
      end
      CMD_ENTER: begin
        if (st.mutex_phase == MX_RELEASED && st.marker_time != '0) begin
          st_nxt.mutex_phase = MX_WANTED;
        end
      end
      CMD_RELEASE: begin
        if (st.mutex_phase == MX_HELD) begin
          st_nxt.mutex_phase = MX_RELEASED;
          m0 = '{1'b1, KIND_MARKER, '0, st.marker_time};
          if (st.clear_deferred) begin
            // marker goes out first, then the held-back clear is handled (leader: new marker, others: clear)
            st_nxt.clear_deferred = 1'b0;
            two = 1'b1;
            if (leader) begin
              st_nxt.marker_time = item.now_time;
              m1 = '{1'b1, KIND_MARKER, '0, item.now_time};
            end else begin
              st_nxt.regen_active = 1'b1;
              st_nxt.marker_time  = '0;
              m1 = '{1'b1, KIND_CLEAR, '0, '0};
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ring_election_token_mutex_node_core.sv =====
`default_nettype none
// Path: an item is captured in the input register, and its results are then registered in the result buffer.
// Throughput: one item per cycle while the output is ready; an item with two results
// holds the output until both are taken, as the single result buffer drains one message per transfer.
// Reset (rst_n low, synchronous): node state goes to init, own_id to 0, and
// both the input register and the result buffer are emptied.

module ring_election_token_mutex_node_core #(
  parameter int ID_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  retm_in_if.sink          in_ch,
  retm_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import retm_pkg::*;

  localparam int IdW = (ID_BITS < FID_W) ? ID_BITS : FID_W;

  logic [IdW-1:0] own_id_r;
  retm_state_t    st_r, st_nxt;
  logic [IdW-1:0] li_r, li_nxt;

  logic           in_v_r;
  retm_item_t     item_r;

  logic           buf_v_r;
  retm_msg_t      m0_r, m1_r, m0_nxt, m1_nxt;
  logic           two_r, two_nxt;
  logic           idx_r;

  logic           out_last;
  logic           advance;
  retm_msg_t      cur;

  retm_step #(.IdW(IdW)) u_step (
    .st               (st_r),
    .leader_ident     (li_r),
    .own_id           (own_id_r),
    .item             (item_r),
    .st_nxt           (st_nxt),
    .leader_ident_nxt (li_nxt),
    .m0               (m0_nxt),
    .m1               (m1_nxt),
    .two              (two_nxt)
  );

  assign out_last    = !two_r || idx_r;
  assign advance     = in_v_r && (!buf_v_r || (out_ch.ready && out_last));
  assign in_ch.ready = !in_v_r || advance;
  assign cur         = idx_r ? m1_r : m0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
    end else if (cfg_we) begin
      own_id_r <= cfg_wdata[IdW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= '{in_ch.cmd, in_ch.msg_kind, in_ch.msg_id, in_ch.msg_stamp, in_ch.now_time};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '{RING_INIT, 1'b0, 1'b0, 1'b0, '0, MX_INIT, 1'b0, 1'b0};
      li_r    <= '0;
      buf_v_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (advance) begin
      st_r    <= st_nxt;
      li_r    <= li_nxt;
      buf_v_r <= 1'b1;
      idx_r   <= 1'b0;
    end else if (buf_v_r && out_ch.ready) begin
      if (out_last) begin
        buf_v_r <= 1'b0;
      end else begin
        idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m0_r  <= m0_nxt;
      m1_r  <= m1_nxt;
      two_r <= two_nxt;
    end
  end

  // status is read straight from the state: a new item only updates it once the
  // buffer has drained
  assign out_ch.valid              = buf_v_r;
  assign out_ch.send_valid         = cur.valid;
  assign out_ch.send_kind          = cur.kind;
  assign out_ch.send_id            = cur.id;
  assign out_ch.send_stamp         = cur.stamp;
  assign out_ch.last               = out_last;
  assign out_ch.ring_state         = st_r.ring_phase;
  assign out_ch.is_participant     = st_r.participant;
  assign out_ch.leader_valid       = st_r.leader_known;
  assign out_ch.leader_id          = st_r.leader_known ? FID_W'(li_r) : '0;
  assign out_ch.access_state       = st_r.mutex_phase;
  assign out_ch.marker_pass_active = st_r.regen_active;

`ifndef SYNTHESIS
  a_idx_two: assert property (@(posedge clk) disable iff (!rst_n)
    buf_v_r && idx_r |-> two_r)
    else $error("second result selected for a single-result item");

  a_advance_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> buf_v_r && !idx_r)
    else $error("result buffer not loaded after advance");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    buf_v_r && two_r && !idx_r && out_ch.ready |=> buf_v_r && idx_r)
    else $error("second result lost");

  a_no_leader_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.leader_known |-> li_r == '0)
    else $error("leader identifier set without a known leader");
`endif

endmodule

`default_nettype wire
